/* design/gcrse_pkg.sv */
// shared types, constants and gcr code functions for the gcr sector encoder
package gcrse_pkg;

    localparam int SECTOR_BYTES = 256;
    localparam int POS_W        = $clog2(SECTOR_BYTES);
    localparam int CMD_DEPTH    = 4;
    localparam int CMD_PTR_W    = $clog2(CMD_DEPTH);
    localparam int SEQ_W        = 5;

    // register indexes on the config port
    localparam logic [1:0] CFG_FORMAT_ID_FIRST  = 2'd0;
    localparam logic [1:0] CFG_FORMAT_ID_SECOND = 2'd1;
    localparam logic [1:0] CFG_INTER_SECTOR_GAP = 2'd2;

    localparam logic [7:0] SYNC_BYTE  = 8'hff;
    localparam logic [7:0] GAP_BYTE   = 8'h55;
    localparam logic [7:0] HEADER_ID  = 8'h08;
    localparam logic [7:0] DATA_ID    = 8'h07;
    localparam logic [7:0] HEADER_PAD = 8'h0f;

    localparam logic [4:0] GAP_RESET = 5'd14;
    localparam logic [4:0] GAP_MIN   = 5'd4;
    localparam logic [4:0] GAP_MAX   = 5'd19;

    // byte positions inside a header run
    localparam logic [SEQ_W-1:0] HDR_SYNC_END = 5'd4;
    localparam logic [SEQ_W-1:0] HDR_G1_END   = 5'd9;
    localparam logic [SEQ_W-1:0] HDR_G2_END   = 5'd14;
    localparam logic [SEQ_W-1:0] HDR_GAP_END  = 5'd23;
    localparam logic [SEQ_W-1:0] HDR_LAST     = 5'd28;
    localparam logic [SEQ_W-1:0] GROUP_LAST   = 5'd4;

    typedef logic [1:0] cmd_kind_t;
    localparam cmd_kind_t CMD_HEADER = 2'd0;
    localparam cmd_kind_t CMD_GROUP  = 2'd1;
    localparam cmd_kind_t CMD_LAST   = 2'd2;

    // one unit of back end work: four bytes to pack plus what follows them
    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
    } cmd_t;

    function automatic logic [4:0] gcr_code(input logic [3:0] nib);
        logic [4:0] c;
        unique case (nib)
            4'h0: c = 5'h0a;
            4'h1: c = 5'h0b;
            4'h2: c = 5'h12;
            4'h3: c = 5'h13;
            4'h4: c = 5'h0e;
            4'h5: c = 5'h0f;
            4'h6: c = 5'h16;
            4'h7: c = 5'h17;
            4'h8: c = 5'h09;
            4'h9: c = 5'h19;
            4'ha: c = 5'h1a;
            4'hb: c = 5'h1b;
            4'hc: c = 5'h0d;
            4'hd: c = 5'h1d;
            4'he: c = 5'h1e;
            4'hf: c = 5'h15;
            default: c = 5'h0a;
        endcase
        return c;
    endfunction

    function automatic logic [39:0] gcr_group(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c, input logic [7:0] d);
        return {gcr_code(a[7:4]), gcr_code(a[3:0]), gcr_code(b[7:4]), gcr_code(b[3:0]),
                gcr_code(c[7:4]), gcr_code(c[3:0]), gcr_code(d[7:4]), gcr_code(d[3:0])};
    endfunction

endpackage

/* design/gcr_sector_track_encoder_top.sv */
// top level of the gcr sector encoder: config registers, front, queue, back
//
// usage
// - input channel (s_): one request per sector data byte, bytes 0 to 255 in
//   order; sector and track numbers are sampled with byte 0 only
// - output channel (m_): one track byte per request on the result side;
//   m_run_last marks the final byte caused by an input request,
//   m_sector_end marks the final gap byte of the sector
// - config port: cfg_wen writes cfg_wdata into register cfg_index
//   (0 first format id, 1 second format id, 2 gap length); write only when idle
// - byte 0 yields 29 bytes (sync, header, gap, data sync), every fourth byte
//   yields a 5 byte gcr group, byte 255 yields its group plus 4 to 19 gap bytes
// - path: the first byte of a request passes the command queue, the sequencer
//   registers and the output register when the back end is idle
// - throughput: the front takes one request per cycle while its 4 entry
//   command queue has room; the back end sends one byte per cycle while m_ready
//   holds, so a sector of 256 requests (354 bytes plus gap) is bound by the output port
// - a stalled receiver only fills the output register and the queue;
//   requests keep going in until the queue is full
// - reset clears position, checksum and queue; no clearing pass is needed
module gcr_sector_track_encoder_top
    import gcrse_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wen,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic [4:0] s_sector_number,
    input  logic [7:0] s_track_number,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_gcr_byte,
    output logic       m_run_last,
    output logic       m_sector_end
);

    // configuration registers
    logic [7:0] format_id_first_reg;
    logic [7:0] format_id_second_reg;
    logic [4:0] inter_sector_gap_reg;

    // front to queue to back
    logic cmd_push, cmd_full, cmd_pop, cmd_avail;
    cmd_t cmd_wr, cmd_rd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            format_id_first_reg  <= 8'h00;
            format_id_second_reg <= 8'h00;
            inter_sector_gap_reg <= GAP_RESET;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                CFG_FORMAT_ID_FIRST:  format_id_first_reg  <= cfg_wdata;
                CFG_FORMAT_ID_SECOND: format_id_second_reg <= cfg_wdata;
                CFG_INTER_SECTOR_GAP: inter_sector_gap_reg <= cfg_wdata[4:0];
                default: ; // unused index, write dropped
            endcase
        end
    end

    // position tracking, checksum, group assembly
    gcrse_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_sector_number  (s_sector_number),
        .s_track_number   (s_track_number),
        .format_id_first  (format_id_first_reg),
        .format_id_second (format_id_second_reg),
        .cmd_full         (cmd_full),
        .cmd_push         (cmd_push),
        .cmd_out          (cmd_wr)
    );

    // decouples request intake from byte output
    gcrse_cmd_fifo u_cmd_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (cmd_push),
        .push_data (cmd_wr),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .avail     (cmd_avail),
        .pop_data  (cmd_rd)
    );

    // byte sequencer with output register
    gcrse_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd_avail        (cmd_avail),
        .cmd_in           (cmd_rd),
        .cmd_pop          (cmd_pop),
        .format_id_first  (format_id_first_reg),
        .format_id_second (format_id_second_reg),
        .inter_sector_gap (inter_sector_gap_reg),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_gcr_byte       (m_gcr_byte),
        .m_run_last       (m_run_last),
        .m_sector_end     (m_sector_end)
    );

    // sector end always closes the request that caused it
    a_end_is_run_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_sector_end |-> m_run_last)
        else $error("sector end without run last");

    // sector end falls on a gap byte
    a_end_is_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_sector_end |-> m_gcr_byte == GAP_BYTE)
        else $error("sector end on a non-gap byte");

    // queue is never pushed while full
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_push |-> !cmd_full)
        else $error("command queue overflow");

    // reset leaves no result pending
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

/* design/gcrse_front.sv */
// front end: takes data bytes, tracks sector position and checksum, builds commands
module gcrse_front
    import gcrse_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic [4:0] s_sector_number,
    input  logic [7:0] s_track_number,
    input  logic [7:0] format_id_first,
    input  logic [7:0] format_id_second,
    input  logic       cmd_full,
    output logic       cmd_push,
    output cmd_t       cmd_out
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       chk_reg, chk_next;
    logic [23:0]      hold_reg, hold_next;
    logic             accept;
    logic [7:0]       sec_ext;
    logic [7:0]       chk_upd;

    assign s_ready = !cmd_full;
    assign accept  = s_valid && s_ready;
    assign sec_ext = {3'b000, s_sector_number};
    assign chk_upd = chk_reg ^ s_data_byte;

    always_comb begin
        pos_next  = pos_reg;
        chk_next  = chk_reg;
        hold_next = hold_reg;
        cmd_push  = 1'b0;
        cmd_out   = '{kind: CMD_GROUP, b0: hold_reg[23:16], b1: hold_reg[15:8],
                      b2: hold_reg[7:0], b3: s_data_byte};
        if (accept) begin
            pos_next = pos_reg + 1'b1;
            if (pos_reg == '0) begin
                cmd_push  = 1'b1;
                cmd_out   = '{kind: CMD_HEADER, b0: HEADER_ID,
                              b1: sec_ext ^ s_track_number ^ format_id_second ^ format_id_first,
                              b2: sec_ext, b3: s_track_number};
                chk_next  = s_data_byte;
                hold_next = {8'h00, DATA_ID, s_data_byte};
            end else if (pos_reg == POS_W'(SECTOR_BYTES - 1)) begin
                cmd_push  = 1'b1;
                cmd_out   = '{kind: CMD_LAST, b0: s_data_byte, b1: chk_upd,
                              b2: 8'h00, b3: 8'h00};
                chk_next  = chk_upd;
                hold_next = '0;
            end else if (pos_reg[1:0] == 2'd2) begin
                // fourth byte of a group
                cmd_push  = 1'b1;
                chk_next  = chk_upd;
                hold_next = '0;
            end else if (pos_reg[1:0] == 2'd3) begin
                chk_next  = chk_upd;
                hold_next = {16'h0000, s_data_byte};
            end else begin
                chk_next  = chk_upd;
                hold_next = {hold_reg[15:0], s_data_byte};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            chk_reg  <= '0;
            hold_reg <= '0;
        end else begin
            pos_reg  <= pos_next;
            chk_reg  <= chk_next;
            hold_reg <= hold_next;
        end
    end

endmodule

/* design/gcrse_cmd_fifo.sv */
// short command queue between front and back end
module gcrse_cmd_fifo
    import gcrse_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output logic avail,
    output cmd_t pop_data
);

    cmd_t                 mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CMD_PTR_W:0]   count_reg, count_next;
    logic                 do_push, do_pop;

    assign full     = (count_reg == (CMD_PTR_W+1)'(CMD_DEPTH));
    assign avail    = (count_reg != '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && avail;
    assign pop_data = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

/* design/gcrse_back.sv */
// back end: expands commands into sync, gcr and gap bytes, one per cycle while m_ready allows
module gcrse_back
    import gcrse_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cmd_avail,
    input  cmd_t       cmd_in,
    output logic       cmd_pop,
    input  logic [7:0] format_id_first,
    input  logic [7:0] format_id_second,
    input  logic [4:0] inter_sector_gap,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_gcr_byte,
    output logic       m_run_last,
    output logic       m_sector_end
);

    logic             busy_reg, busy_next;
    cmd_kind_t        kind_reg, kind_next;
    logic [SEQ_W-1:0] idx_reg, idx_next;
    logic [SEQ_W-1:0] end_reg, end_next;
    logic [39:0]      word_reg, word_next;
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       m_byte_reg, m_byte_next;
    logic             m_run_last_reg, m_run_last_next;
    logic             m_sector_end_reg, m_sector_end_next;

    logic             out_adv, fire, is_final, word_sel;
    logic [7:0]       byte_sel;
    logic [4:0]       gap_eff;

    assign out_adv = !m_valid_reg || m_ready;
    assign fire    = busy_reg && out_adv;
    assign cmd_pop = cmd_avail && (!busy_reg || (fire && is_final));

    always_comb begin
        if (inter_sector_gap < GAP_MIN) begin
            gap_eff = GAP_MIN;
        end else if (inter_sector_gap > GAP_MAX) begin
            gap_eff = GAP_MAX;
        end else begin
            gap_eff = inter_sector_gap;
        end
    end

    // byte of the current position
    always_comb begin
        unique case (kind_reg)
            CMD_HEADER: begin
                is_final = (idx_reg == HDR_LAST);
                if (idx_reg <= HDR_SYNC_END) begin
                    byte_sel = SYNC_BYTE;
                    word_sel = 1'b0;
                end else if (idx_reg <= HDR_G2_END) begin
                    byte_sel = word_reg[39:32];
                    word_sel = 1'b1;
                end else if (idx_reg <= HDR_GAP_END) begin
                    byte_sel = GAP_BYTE;
                    word_sel = 1'b0;
                end else begin
                    byte_sel = SYNC_BYTE;
                    word_sel = 1'b0;
                end
            end
            CMD_GROUP: begin
                is_final = (idx_reg == GROUP_LAST);
                byte_sel = word_reg[39:32];
                word_sel = 1'b1;
            end
            CMD_LAST: begin
                is_final = (idx_reg == end_reg);
                word_sel = (idx_reg <= GROUP_LAST);
                byte_sel = word_sel ? word_reg[39:32] : GAP_BYTE;
            end
            default: begin
                is_final = 1'b1;
                byte_sel = GAP_BYTE;
                word_sel = 1'b0;
            end
        endcase
    end

    always_comb begin
        busy_next = busy_reg;
        kind_next = kind_reg;
        idx_next  = idx_reg;
        end_next  = end_reg;
        word_next = word_reg;
        if (fire) begin
            idx_next = idx_reg + 1'b1;
            if (is_final) begin
                busy_next = 1'b0;
            end
            if (kind_reg == CMD_HEADER && idx_reg == HDR_G1_END) begin
                word_next = gcr_group(format_id_second, format_id_first,
                                      HEADER_PAD, HEADER_PAD);
            end else if (word_sel) begin
                word_next = {word_reg[31:0], 8'h00};
            end
        end
        if (cmd_pop) begin
            busy_next = 1'b1;
            kind_next = cmd_in.kind;
            idx_next  = '0;
            end_next  = GROUP_LAST + gap_eff;
            word_next = gcr_group(cmd_in.b0, cmd_in.b1, cmd_in.b2, cmd_in.b3);
        end
    end

    // output register
    always_comb begin
        m_valid_next      = m_valid_reg;
        m_byte_next       = m_byte_reg;
        m_run_last_next   = m_run_last_reg;
        m_sector_end_next = m_sector_end_reg;
        if (out_adv) begin
            m_valid_next      = fire;
            m_byte_next       = byte_sel;
            m_run_last_next   = is_final;
            m_sector_end_next = is_final && (kind_reg == CMD_LAST);
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg         <= kind_next;
        idx_reg          <= idx_next;
        end_reg          <= end_next;
        word_reg         <= word_next;
        m_byte_reg       <= m_byte_next;
        m_run_last_reg   <= m_run_last_next;
        m_sector_end_reg <= m_sector_end_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_gcr_byte   = m_byte_reg;
    assign m_run_last   = m_run_last_reg;
    assign m_sector_end = m_sector_end_reg;

endmodule

/* bench/gcr_sector_track_encoder_top_test.sv */
// testbench for the gcr sector track encoder: a full sector and the start of the next
`timescale 1ns / 1ps

module gcr_sector_track_encoder_top_test;
    import gcrse_pkg::*;

    // run shape
    localparam int unsigned SECTOR_LEN    = 256;
    localparam int unsigned TAIL_LEN      = 14;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned DRAIN_LIMIT   = 20000;
    localparam int unsigned PRINT_LIMIT   = 100;
    localparam int unsigned RUN_LIMIT_NS  = 1_000_000;

    // index past the last register, writes to it must change nothing
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    // track format constants, kept apart from the design package on purpose
    localparam logic [7:0]  SYNC_VAL      = 8'hff;
    localparam logic [7:0]  GAP_VAL       = 8'h55;
    localparam logic [7:0]  HDR_BLOCK_ID  = 8'h08;
    localparam logic [7:0]  DATA_BLOCK_ID = 8'h07;
    localparam logic [7:0]  HDR_FILL      = 8'h0f;
    localparam logic [7:0]  LAST_POS      = 8'hff;
    localparam logic [4:0]  GAP_DEFAULT   = 5'd14;
    localparam int unsigned SYNC_RUN      = 5;
    localparam int unsigned HDR_GAP_RUN   = 9;
    localparam int unsigned GAP_LO        = 4;
    localparam int unsigned GAP_HI        = 19;

    typedef struct packed {
        logic [7:0] gcr_byte;
        logic       run_last;
        logic       sector_end;
    } track_byte_t;

    // mirror of the encoder plus the queue of track bytes still owed by the block
    class track_byte_scoreboard;
        logic [4:0]  nibble_code [16];
        logic [7:0]  first_id;
        logic [7:0]  second_id;
        logic [4:0]  gap_setting;
        logic [7:0]  position;
        logic [7:0]  checksum;
        logic [23:0] held;
        track_byte_t track_q[$];
        int unsigned mismatches;
        int unsigned bytes_seen;

        function new();
            nibble_code = '{5'h0a, 5'h0b, 5'h12, 5'h13, 5'h0e, 5'h0f, 5'h16, 5'h17,
                            5'h09, 5'h19, 5'h1a, 5'h1b, 5'h0d, 5'h1d, 5'h1e, 5'h15};
            first_id    = '0;
            second_id   = '0;
            gap_setting = GAP_DEFAULT;
            position    = '0;
            checksum    = '0;
            held        = '0;
            mismatches  = 0;
            bytes_seen  = 0;
        endfunction

        function void write_register(input logic [1:0] index, input logic [7:0] value);
            case (index)
                CFG_FORMAT_ID_FIRST:  first_id = value;
                CFG_FORMAT_ID_SECOND: second_id = value;
                CFG_INTER_SECTOR_GAP: gap_setting = value[4:0];
                default: ;
            endcase
        endfunction

        function void put(input logic [7:0] value, input logic is_end);
            track_byte_t t;
            t.gcr_byte   = value;
            t.run_last   = 1'b0;
            t.sector_end = is_end;
            track_q.push_back(t);
        endfunction

        function void put_run(input logic [7:0] value, input int unsigned count);
            int unsigned i;
            for (i = 0; i < count; i++)
                put(value, 1'b0);
        endfunction

        // four bytes become eight 5 bit codes, sent as five bytes, high bits first
        function void put_group(input logic [7:0] a, input logic [7:0] b,
                                input logic [7:0] c, input logic [7:0] d);
            logic [31:0] raw;
            logic [39:0] coded;
            int i;
            raw   = {a, b, c, d};
            coded = '0;
            for (i = 7; i >= 0; i--)
                coded = {coded[34:0], nibble_code[raw[4*i +: 4]]};
            for (i = 4; i >= 0; i--)
                put(coded[8*i +: 8], 1'b0);
        endfunction

        function void note_request(input logic [7:0] data, input logic [4:0] sec,
                                   input logic [7:0] trk);
            int unsigned start;
            int unsigned gap;
            track_byte_t t;
            start = track_q.size();
            if (position == 8'd0) begin
                // header, gap and data sync ahead of the first data group
                put_run(SYNC_VAL, SYNC_RUN);
                put_group(HDR_BLOCK_ID, {3'b000, sec} ^ trk ^ second_id ^ first_id,
                          {3'b000, sec}, trk);
                put_group(second_id, first_id, HDR_FILL, HDR_FILL);
                put_run(GAP_VAL, HDR_GAP_RUN);
                put_run(SYNC_VAL, SYNC_RUN);
                checksum = data;
                held     = {8'h00, DATA_BLOCK_ID, data};
            end else begin
                checksum ^= data;
                if (position == LAST_POS) begin
                    // out of range gap settings clamp to the legal span
                    if (gap_setting < GAP_LO)
                        gap = GAP_LO;
                    else if (gap_setting > GAP_HI)
                        gap = GAP_HI;
                    else
                        gap = gap_setting;
                    put_group(data, checksum, 8'h00, 8'h00);
                    put_run(GAP_VAL, gap - 1);
                    put(GAP_VAL, 1'b1);
                    held = '0;
                end else if (position[1:0] == 2'd2) begin
                    put_group(held[23:16], held[15:8], held[7:0], data);
                    held = '0;
                end else if (position[1:0] == 2'd3) begin
                    held = {16'h0000, data};
                end else begin
                    held = {held[15:0], data};
                end
            end
            position = position + 8'd1;
            if (track_q.size() > start) begin
                t          = track_q.pop_back();
                t.run_last = 1'b1;
                track_q.push_back(t);
            end
        endfunction

        task report_mismatch(input string what);
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
                $display("mismatch at %0t ns: %s", $time, what);
        endtask

        task check_result(input logic [7:0] gcr, input logic last, input logic send);
            track_byte_t want;
            if (track_q.size() == 0) begin
                report_mismatch($sformatf("track byte %h with nothing owed", gcr));
            end else begin
                want = track_q.pop_front();
                if (gcr !== want.gcr_byte)
                    report_mismatch($sformatf("byte %0d gcr_byte %h, want %h",
                                              bytes_seen, gcr, want.gcr_byte));
                if (last !== want.run_last)
                    report_mismatch($sformatf("byte %0d run_last %b, want %b",
                                              bytes_seen, last, want.run_last));
                if (send !== want.sector_end)
                    report_mismatch($sformatf("byte %0d sector_end %b, want %b",
                                              bytes_seen, send, want.sector_end));
            end
            bytes_seen++;
        endtask
    endclass

    logic       aclk;
    logic       aresetn;
    logic       cfg_wen;
    logic [1:0] cfg_index;
    logic [7:0] cfg_wdata;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_data_byte;
    logic [4:0] s_sector_number;
    logic [7:0] s_track_number;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_gcr_byte;
    logic       m_run_last;
    logic       m_sector_end;

    track_byte_scoreboard scoreboard;

    // request side runs without gaps while this is set
    logic in_burst;

    // first bytes of the opening sector: all ones, all zeros, alternating bits, every nibble
    logic [7:0] opening_bytes [16] = '{8'h00, 8'hff, 8'h55, 8'haa, 8'h0f, 8'hf0, 8'h01, 8'h80,
                                       8'h12, 8'h34, 8'h56, 8'h78, 8'h9a, 8'hbc, 8'hde, 8'hf1};

    gcr_sector_track_encoder_top i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wen         (cfg_wen),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_sector_number (s_sector_number),
        .s_track_number  (s_track_number),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_gcr_byte      (m_gcr_byte),
        .m_run_last      (m_run_last),
        .m_sector_end    (m_sector_end)
    );

    // 4 ns clock
    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // one request: optional gap, then valid held until the block takes it
    task automatic send_request(input logic [7:0] data, input logic [4:0] sec,
                                input logic [7:0] trk);
        int unsigned pause;
        pause = in_burst ? 0 : $urandom_range(0, 7);
        @(negedge aclk);
        if (pause != 0) begin
            s_valid = 1'b0;
            repeat (pause) @(negedge aclk);
        end
        s_valid         = 1'b1;
        s_data_byte     = data;
        s_sector_number = sec;
        s_track_number  = trk;
        do @(posedge aclk); while (!s_ready);
        scoreboard.note_request(data, sec, trk);
    endtask

    // wait until every owed track byte has come out, then let the block settle
    task automatic drain();
        int unsigned waited;
        waited = 0;
        while (scoreboard.track_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // the first count requests of a sector; sector and track only count on byte 0,
    // the other bytes carry random values there that the block must ignore
    task automatic run_sector(input logic [4:0] sec, input logic [7:0] trk,
                              input bit directed, input int unsigned count);
        logic [7:0] data;
        int unsigned i;
        for (i = 0; i < count; i++) begin
            if (i % 32 == 0)
                in_burst = ($urandom_range(0, 3) == 0);
            data = (directed && i < 16) ? opening_bytes[i] : 8'($urandom);
            if (i == 0)
                send_request(data, sec, trk);
            else
                send_request(data, 5'($urandom), 8'($urandom));
        end
        @(negedge aclk);
        s_valid = 1'b0;
        drain();
    endtask

    task automatic write_register(input logic [1:0] index, input logic [7:0] value);
        @(negedge aclk);
        cfg_wen   = 1'b1;
        cfg_index = index;
        cfg_wdata = value;
        @(posedge aclk);
        scoreboard.write_register(index, value);
    endtask

    // all three registers, then a stray write past the last index
    task automatic configure(input logic [7:0] first, input logic [7:0] second,
                             input logic [7:0] gap_raw);
        write_register(CFG_FORMAT_ID_FIRST, first);
        write_register(CFG_FORMAT_ID_SECOND, second);
        write_register(CFG_INTER_SECTOR_GAP, gap_raw);
        write_register(CFG_UNUSED, 8'($urandom));
        @(negedge aclk);
        cfg_wen = 1'b0;
    endtask

    // result side: random stalls per track byte, with stall free stretches
    initial begin
        int unsigned pause;
        int unsigned taken;
        logic        out_burst;
        m_ready   = 1'b0;
        taken     = 0;
        out_burst = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (taken % 32 == 0)
                out_burst = ($urandom_range(0, 3) == 0);
            pause = out_burst ? 0 : $urandom_range(0, 7);
            @(negedge aclk);
            if (pause != 0) begin
                m_ready = 1'b0;
                repeat (pause) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            scoreboard.check_result(m_gcr_byte, m_run_last, m_sector_end);
            taken++;
        end
    end

    // main sequence
    initial begin
        aresetn         = 1'b0;
        cfg_wen         = 1'b0;
        cfg_index       = '0;
        cfg_wdata       = '0;
        s_valid         = 1'b0;
        s_data_byte     = '0;
        s_sector_number = '0;
        s_track_number  = '0;
        in_burst        = 1'b0;
        scoreboard      = new();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset values: zero format ids, default gap, all zero header fields
        run_sector(5'd0, 8'd0, 1'b1, SECTOR_LEN);

        // top ids and numbers on the header of the next sector after the wrap;
        // gap field of zero with high data bits set would clamp up, but this short run never reaches it
        configure(8'hff, 8'hff, 8'he0);
        run_sector(5'd31, 8'd255, 1'b0, TAIL_LEN);

        if (scoreboard.track_q.size() != 0)
            scoreboard.report_mismatch($sformatf("%0d track bytes never arrived",
                                                 scoreboard.track_q.size()));
        if (scoreboard.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // hard stop well past the slowest legal run
    initial begin
        #(RUN_LIMIT_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
